@@ src/tensor_axis_sum_address_gen_macros.svh @@
// Assertion macros for the tensor axis sum address generator.
`ifndef TENSOR_AXIS_SUM_ADDRESS_GEN_MACROS_SVH
`define TENSOR_AXIS_SUM_ADDRESS_GEN_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSAG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSAG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/tsag_pkg.sv @@
// Shared widths, types and helpers of the tensor axis sum address generator.
package tsag_pkg;

    localparam int DIM_BITS         = 16;
    localparam int OFFSET_BITS      = 32;
    localparam int DEFAULT_MAX_RANK = 4;
    localparam int CFG_W            = 64;
    localparam int FIELDS           = CFG_W / DIM_BITS;
    localparam int KEPT_SLOTS       = 4;
    localparam int PROD_W           = 2 * DIM_BITS;

    typedef logic [DIM_BITS-1:0] dim_t;

    typedef struct packed {
        logic load;
        logic step;
        logic clear;
        logic active;
    } cell_ctrl_t;

    function automatic dim_t field_of(input logic [CFG_W-1:0] word, input int unsigned idx);
        dim_t result;
        result = '0;
        if (idx < FIELDS) begin
            result = word[idx*DIM_BITS +: DIM_BITS];
        end
        return result;
    endfunction

endpackage

@@ src/tsag_cell.sv @@
// One axis cell: index counter with carry chain, product stage and partial sum hand-off.
module tsag_cell
    import tsag_pkg::*;
#(
    parameter int SUM_W = PROD_W + 3
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cell_ctrl_t       ctrl,
    input  dim_t             len,
    input  logic             carry_in,
    output logic             carry_out,
    output dim_t             count,
    input  dim_t             src_stride,
    input  dim_t             dst_stride,
    input  dim_t             dst_count,
    input  logic [SUM_W-1:0] src_sum_in,
    input  logic [SUM_W-1:0] dst_sum_in,
    output logic [SUM_W-1:0] src_sum_out,
    output logic [SUM_W-1:0] dst_sum_out
);

    dim_t              count_reg;
    dim_t              count_next;
    logic [DIM_BITS:0] count_inc;
    logic              wrap;
    logic [PROD_W-1:0] src_prod_reg;
    logic [PROD_W-1:0] src_prod_next;
    logic [PROD_W-1:0] dst_prod_reg;
    logic [PROD_W-1:0] dst_prod_next;

    always_comb begin
        count_inc = (DIM_BITS+1)'(count_reg) + (DIM_BITS+1)'(1);
        wrap      = !(count_inc < (DIM_BITS+1)'(len));
        carry_out = ctrl.active ? (carry_in && wrap) : carry_in;
        count_next = count_reg;
        if (ctrl.clear) begin
            count_next = '0;
        end else if (ctrl.step && ctrl.active && carry_in) begin
            count_next = wrap ? '0 : count_inc[DIM_BITS-1:0];
        end
        src_prod_next = PROD_W'(count_reg) * PROD_W'(src_stride);
        dst_prod_next = PROD_W'(dst_count) * PROD_W'(dst_stride);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            src_prod_reg <= src_prod_next;
            dst_prod_reg <= dst_prod_next;
        end
    end

    assign count       = count_reg;
    assign src_sum_out = src_sum_in + SUM_W'(src_prod_reg);
    assign dst_sum_out = dst_sum_in + SUM_W'(dst_prod_reg);

endmodule

@@ src/tensor_axis_sum_address_gen.sv @@
// Top level of the tensor axis sum address generator: config port, phase control, cell row.
// Path: the cell product registers, then the output register. Throughput: one tick transaction
// per cycle unless m_ stalls; the counter carry ripples through the cells in the accept cycle,
// products are registered in each cell, partial sums are summed next.
// Reset: aresetn is synchronous and active low; it loads the register reset values,
// sets the phase to done and clears all axis counters. There is no memory and no clearing pass.
`include "tensor_axis_sum_address_gen_macros.svh"

module tensor_axis_sum_address_gen
    import tsag_pkg::*;
#(
    parameter int MAX_RANK = DEFAULT_MAX_RANK
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [5:0]             paddr,
    input  logic [CFG_W-1:0]       pwdata,
    output logic [CFG_W-1:0]       prdata,
    output logic                   pready,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_restart,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_command_kind,
    output logic [OFFSET_BITS-1:0] m_source_offset,
    output logic [OFFSET_BITS-1:0] m_dest_offset,
    output logic                   m_offset_overflow,
    output logic                   m_final_command
);

    localparam int RANK_LIM = (FIELDS < MAX_RANK) ? FIELDS : MAX_RANK;
    localparam int KEPT_LIM = (MAX_RANK < KEPT_SLOTS) ? MAX_RANK : KEPT_SLOTS;
    localparam int SUM_W    = PROD_W + $clog2(MAX_RANK + 1);

    localparam logic [1:0] PH_DONE = 2'd0;
    localparam logic [1:0] PH_ZERO = 2'd1;
    localparam logic [1:0] PH_ADD  = 2'd2;

    localparam logic [2:0] REG_INPUT_RANK     = 3'd0;
    localparam logic [2:0] REG_INPUT_DIMS     = 3'd1;
    localparam logic [2:0] REG_INPUT_STRIDES  = 3'd2;
    localparam logic [2:0] REG_KEPT_COUNT     = 3'd3;
    localparam logic [2:0] REG_KEPT_AXES      = 3'd4;
    localparam logic [2:0] REG_OUTPUT_STRIDES = 3'd5;

    logic [2:0]       input_rank_reg;
    logic [CFG_W-1:0] input_dims_reg;
    logic [CFG_W-1:0] input_strides_reg;
    logic [2:0]       kept_count_reg;
    logic [7:0]       kept_axes_reg;
    logic [CFG_W-1:0] output_strides_reg;

    logic [2:0] reg_sel;
    logic       cfg_write;

    logic [1:0] phase_reg;
    logic [1:0] phase_next;

    logic [2:0] rank_eff;
    logic [2:0] kept_eff;
    logic [1:0] kept_ax [KEPT_SLOTS];
    dim_t       kept_len [KEPT_SLOTS];
    dim_t       count_view [KEPT_SLOTS];
    logic       in_empty;
    logic       out_empty;

    logic accept;
    logic issue;
    logic clear_all;
    logic done_chain;
    logic final_cmd;
    logic count_nonzero;

    logic st1_valid_reg;
    logic st1_valid_next;
    logic st1_kind_reg;
    logic st1_kind_next;
    logic st1_final_reg;
    logic st1_final_next;
    logic out_ready;

    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic                   m_kind_reg;
    logic [OFFSET_BITS-1:0] m_src_reg;
    logic [OFFSET_BITS-1:0] m_dst_reg;
    logic                   m_ovf_reg;
    logic                   m_final_reg;
    logic                   ovf_w;

    logic       carry [MAX_RANK+1];
    dim_t       count_w [MAX_RANK];
    logic [SUM_W-1:0] src_sum [MAX_RANK+1];
    logic [SUM_W-1:0] dst_sum [MAX_RANK+1];

    // Configuration port.
    assign pready    = 1'b1;
    assign reg_sel   = paddr[5:3];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            input_rank_reg     <= 3'd1;
            input_dims_reg     <= '0;
            input_strides_reg  <= '0;
            kept_count_reg     <= '0;
            kept_axes_reg      <= '0;
            output_strides_reg <= '0;
        end else if (cfg_write) begin
            unique case (reg_sel)
                REG_INPUT_RANK:     input_rank_reg     <= pwdata[2:0];
                REG_INPUT_DIMS:     input_dims_reg     <= pwdata;
                REG_INPUT_STRIDES:  input_strides_reg  <= pwdata;
                REG_KEPT_COUNT:     kept_count_reg     <= pwdata[2:0];
                REG_KEPT_AXES:      kept_axes_reg      <= pwdata[7:0];
                REG_OUTPUT_STRIDES: output_strides_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_INPUT_RANK:     prdata = CFG_W'(input_rank_reg);
            REG_INPUT_DIMS:     prdata = input_dims_reg;
            REG_INPUT_STRIDES:  prdata = input_strides_reg;
            REG_KEPT_COUNT:     prdata = CFG_W'(kept_count_reg);
            REG_KEPT_AXES:      prdata = CFG_W'(kept_axes_reg);
            REG_OUTPUT_STRIDES: prdata = output_strides_reg;
            default:            prdata = '0;
        endcase
    end

    // Effective shape and emptiness checks.
    always_comb begin
        rank_eff  = (input_rank_reg > 3'(RANK_LIM)) ? 3'(RANK_LIM) : input_rank_reg;
        kept_eff  = (kept_count_reg > 3'(KEPT_LIM)) ? 3'(KEPT_LIM) : kept_count_reg;
        in_empty  = 1'b0;
        out_empty = 1'b0;
        for (int a = 0; a < FIELDS; a++) begin
            if ((3'(a) < rank_eff) && (field_of(input_dims_reg, a) == '0)) begin
                in_empty = 1'b1;
            end
        end
        for (int k = 0; k < KEPT_SLOTS; k++) begin
            kept_ax[k]  = kept_axes_reg[2*k +: 2];
            kept_len[k] = ({1'b0, kept_ax[k]} < rank_eff) ?
                          field_of(input_dims_reg, kept_ax[k]) : dim_t'(1);
            if ((3'(k) < kept_eff) && (kept_len[k] == '0)) begin
                out_empty = 1'b1;
            end
        end
    end

    // Phase control.
    assign s_ready   = !st1_valid_reg || out_ready;
    assign accept    = s_valid && s_ready;
    assign issue     = accept && !s_restart && (phase_reg != PH_DONE);
    assign clear_all = accept && (s_restart || (issue && done_chain));
    assign final_cmd = done_chain && (((phase_reg == PH_ZERO) && in_empty) ||
                                      (phase_reg == PH_ADD));

    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            if (s_restart) begin
                phase_next = out_empty ? PH_DONE : PH_ZERO;
            end else begin
                unique case (phase_reg)
                    PH_ZERO: if (done_chain) phase_next = in_empty ? PH_DONE : PH_ADD;
                    PH_ADD:  if (done_chain) phase_next = PH_DONE;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_DONE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    // Row of axis cells.
    assign carry[0]   = 1'b1;
    assign src_sum[0] = '0;
    assign dst_sum[0] = '0;
    assign done_chain = carry[MAX_RANK];

    for (genvar a = 0; a < KEPT_SLOTS; a++) begin : g_view
        if (a < MAX_RANK) begin : g_cell_count
            assign count_view[a] = count_w[a];
        end else begin : g_no_cell
            assign count_view[a] = '0;
        end
    end

    for (genvar i = 0; i < MAX_RANK; i++) begin : g_cells
        cell_ctrl_t ctrl;
        dim_t       len;
        dim_t       src_stride;
        dim_t       dst_stride;
        dim_t       dst_count;
        logic       in_rank;

        assign in_rank = 3'(i) < rank_eff;

        if (i < KEPT_SLOTS) begin : g_kept
            logic kept_on;
            logic ax_in_rank;
            assign kept_on    = 3'(i) < kept_eff;
            assign ax_in_rank = {1'b0, kept_ax[i]} < rank_eff;
            assign len = (phase_reg == PH_ZERO) ? kept_len[i] :
                         (in_rank ? field_of(input_dims_reg, i) : dim_t'(1));
            assign ctrl.active = (phase_reg == PH_ZERO) ? kept_on : in_rank;
            assign dst_stride  = (kept_on && ((phase_reg == PH_ZERO) || ax_in_rank)) ?
                                 field_of(output_strides_reg, i) : '0;
            assign dst_count   = (phase_reg == PH_ZERO) ? count_w[i] : count_view[kept_ax[i]];
        end else begin : g_plain
            assign len         = in_rank ? field_of(input_dims_reg, i) : dim_t'(1);
            assign ctrl.active = (phase_reg == PH_ADD) && in_rank;
            assign dst_stride  = '0;
            assign dst_count   = '0;
        end

        assign src_stride = ((phase_reg == PH_ADD) && in_rank) ?
                            field_of(input_strides_reg, i) : '0;
        assign ctrl.load  = s_ready;
        assign ctrl.step  = issue;
        assign ctrl.clear = clear_all;

        tsag_cell #(
            .SUM_W (SUM_W)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .len         (len),
            .carry_in    (carry[i]),
            .carry_out   (carry[i+1]),
            .count       (count_w[i]),
            .src_stride  (src_stride),
            .dst_stride  (dst_stride),
            .dst_count   (dst_count),
            .src_sum_in  (src_sum[i]),
            .dst_sum_in  (dst_sum[i]),
            .src_sum_out (src_sum[i+1]),
            .dst_sum_out (dst_sum[i+1])
        );
    end

    always_comb begin
        count_nonzero = 1'b0;
        for (int i = 0; i < MAX_RANK; i++) begin
            if (count_w[i] != '0) begin
                count_nonzero = 1'b1;
            end
        end
    end

    // Product stage control.
    always_comb begin
        st1_valid_next = st1_valid_reg;
        st1_kind_next  = st1_kind_reg;
        st1_final_next = st1_final_reg;
        if (s_ready) begin
            st1_valid_next = issue;
            st1_kind_next  = (phase_reg == PH_ADD);
            st1_final_next = final_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        st1_kind_reg  <= st1_kind_next;
        st1_final_reg <= st1_final_next;
    end

    // Output register.
    assign out_ready    = !m_valid_reg || m_ready;
    assign ovf_w        = (|src_sum[MAX_RANK][SUM_W-1:OFFSET_BITS]) ||
                          (|dst_sum[MAX_RANK][SUM_W-1:OFFSET_BITS]);
    assign m_valid_next = out_ready ? st1_valid_reg : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && st1_valid_reg) begin
            m_kind_reg  <= st1_kind_reg;
            m_src_reg   <= src_sum[MAX_RANK][OFFSET_BITS-1:0];
            m_dst_reg   <= dst_sum[MAX_RANK][OFFSET_BITS-1:0];
            m_ovf_reg   <= ovf_w;
            m_final_reg <= st1_final_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_command_kind    = m_kind_reg;
    assign m_source_offset   = m_src_reg;
    assign m_dest_offset     = m_dst_reg;
    assign m_offset_overflow = m_ovf_reg;
    assign m_final_command   = m_final_reg;

    `TSAG_ASSERT_NEXT(a_stage_moves_out, st1_valid_reg && out_ready, m_valid, "Pending command did not reach the output register.")
    `TSAG_ASSERT_NEXT(a_restart_issues_nothing, accept && s_restart, !st1_valid_reg, "A restart transaction produced a command.")
    `TSAG_ASSERT_NOW(a_final_ends_walk, st1_valid_reg && st1_final_reg, phase_reg == PH_DONE, "Final command pending while a walk is still active.")
    `TSAG_ASSERT_NOW(a_done_counters_clear, phase_reg == PH_DONE, !count_nonzero, "Axis counters are not cleared while no walk is active.")

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the tensor axis sum address generator command stream.
module tb_top;
    import tsag_pkg::*;

    typedef enum logic [2:0] {
        REG_INPUT_RANK,
        REG_INPUT_DIMS,
        REG_INPUT_STRIDES,
        REG_KEPT_COUNT,
        REG_KEPT_AXES,
        REG_OUTPUT_STRIDES
    } cfg_reg_e;

    typedef enum logic {
        CMD_ZERO = 1'b0,
        CMD_ADD  = 1'b1
    } cmd_kind_e;

    typedef enum logic [1:0] {
        WALK_DONE,
        WALK_ZERO,
        WALK_ADD
    } walk_phase_e;

    typedef struct packed {
        cmd_kind_e   kind;
        logic [31:0] source;
        logic [31:0] dest;
        logic        overflow;
        logic        last;
    } command_t;

    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_TICKS   = 1600;
    localparam int WALK_TICK_CAP  = 100;
    localparam int DEEP_WALK      = 16500;

    class command_scoreboard;
        logic [2:0]  rank_reg;
        logic [63:0] dims_reg;
        logic [63:0] in_stride_reg;
        logic [2:0]  kept_count_reg;
        logic [7:0]  kept_axes_reg;
        logic [63:0] out_stride_reg;
        walk_phase_e phase;
        logic [15:0] axis_index [4];
        command_t    expected_commands [$];
        int          errors;

        function new();
            rank_reg       = 3'd1;
            dims_reg       = '0;
            in_stride_reg  = '0;
            kept_count_reg = '0;
            kept_axes_reg  = '0;
            out_stride_reg = '0;
            phase          = WALK_DONE;
            errors         = 0;
            clear_indices();
        endfunction

        function void set_reg(cfg_reg_e idx, logic [63:0] value);
            case (idx)
                REG_INPUT_RANK:     rank_reg       = value[2:0];
                REG_INPUT_DIMS:     dims_reg       = value;
                REG_INPUT_STRIDES:  in_stride_reg  = value;
                REG_KEPT_COUNT:     kept_count_reg = value[2:0];
                REG_KEPT_AXES:      kept_axes_reg  = value[7:0];
                REG_OUTPUT_STRIDES: out_stride_reg = value;
                default: ;
            endcase
        endfunction

        function void clear_indices();
            for (int i = 0; i < 4; i++) axis_index[i] = '0;
        endfunction

        function int unsigned rank_now();
            return (rank_reg > 3'd4) ? 4 : int'(rank_reg);
        endfunction

        function int unsigned kept_now();
            return (kept_count_reg > 3'd4) ? 4 : int'(kept_count_reg);
        endfunction

        function int unsigned dim(logic [63:0] word, int unsigned k);
            return word[k*16 +: 16];
        endfunction

        function int unsigned kept_axis(int unsigned k);
            return kept_axes_reg[k*2 +: 2];
        endfunction

        function int unsigned axis_length(int unsigned a);
            return (a < rank_now()) ? dim(dims_reg, a) : 1;
        endfunction

        // Ripple the index counters; returns one when the walk carries out of the last axis.
        function bit step_indices(int unsigned n, bit output_side);
            int unsigned len;
            logic [16:0] next;
            for (int unsigned i = 0; i < n && i < 4; i++) begin
                len  = output_side ? axis_length(kept_axis(i)) : axis_length(i);
                next = {1'b0, axis_index[i]} + 17'd1;
                if (next < len) begin
                    axis_index[i] = next[15:0];
                    return 1'b0;
                end
                axis_index[i] = '0;
            end
            return 1'b1;
        endfunction

        function bit input_empty();
            for (int unsigned a = 0; a < rank_now(); a++)
                if (dim(dims_reg, a) == 0) return 1'b1;
            return 1'b0;
        endfunction

        function bit output_empty();
            for (int unsigned k = 0; k < kept_now(); k++)
                if (axis_length(kept_axis(k)) == 0) return 1'b1;
            return 1'b0;
        endfunction

        function longint unsigned commands_in_walk();
            longint unsigned zeros, adds;
            if (output_empty()) return 0;
            zeros = 1;
            adds  = 1;
            for (int unsigned k = 0; k < kept_now(); k++) zeros *= axis_length(kept_axis(k));
            for (int unsigned a = 0; a < rank_now(); a++) adds *= dim(dims_reg, a);
            if (zeros > 1000000 || adds > 1000000) return 1000000;
            return zeros + adds;
        endfunction

        function void predict_tick(bit restart);
            longint unsigned src, dst;
            int unsigned r, kc, a;
            command_t c;
            r   = rank_now();
            kc  = kept_now();
            src = 0;
            dst = 0;
            c   = '0;
            if (restart) begin
                clear_indices();
                phase = output_empty() ? WALK_DONE : WALK_ZERO;
                return;
            end
            if (phase == WALK_DONE) return;
            if (phase == WALK_ZERO) begin
                c.kind = CMD_ZERO;
                for (int unsigned k = 0; k < kc; k++)
                    dst += 64'(axis_index[k]) * 64'(dim(out_stride_reg, k));
                if (step_indices(kc, 1'b1)) begin
                    clear_indices();
                    if (input_empty()) begin
                        phase  = WALK_DONE;
                        c.last = 1'b1;
                    end else begin
                        phase = WALK_ADD;
                    end
                end
            end else begin
                c.kind = CMD_ADD;
                for (int unsigned k = 0; k < r; k++)
                    src += 64'(axis_index[k]) * 64'(dim(in_stride_reg, k));
                for (int unsigned k = 0; k < kc; k++) begin
                    a = kept_axis(k);
                    if (a < r) dst += 64'(axis_index[a]) * 64'(dim(out_stride_reg, k));
                end
                if (step_indices(r, 1'b0)) begin
                    clear_indices();
                    phase  = WALK_DONE;
                    c.last = 1'b1;
                end
            end
            c.overflow = (src[63:32] != 0) || (dst[63:32] != 0);
            c.source   = src[31:0];
            c.dest     = dst[31:0];
            expected_commands.push_back(c);
        endfunction

        function void compare(string what, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
                errors++;
            end
        endfunction

        function void check_command(logic kind, logic [31:0] src, logic [31:0] dst,
                                    logic ovf, logic last);
            command_t want;
            if (expected_commands.size() == 0) begin
                $display("%0t: unexpected command kind %0h source %0h dest %0h",
                         $time, kind, src, dst);
                errors++;
                return;
            end
            want = expected_commands.pop_front();
            compare("command_kind", want.kind, kind);
            compare("source_offset", want.source, src);
            compare("dest_offset", want.dest, dst);
            compare("offset_overflow", want.overflow, ovf);
            compare("final_command", want.last, last);
        endfunction

        function int pending();
            return expected_commands.size();
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [5:0]             paddr;
    logic [CFG_W-1:0]       pwdata;
    logic [CFG_W-1:0]       prdata;
    logic                   pready;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_restart;
    logic                   m_valid;
    logic                   m_ready;
    logic                   m_command_kind;
    logic [OFFSET_BITS-1:0] m_source_offset;
    logic [OFFSET_BITS-1:0] m_dest_offset;
    logic                   m_offset_overflow;
    logic                   m_final_command;

    bit no_idle;
    bit hold_off_request;

    command_scoreboard board = new();

    tensor_axis_sum_address_gen u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_restart         (s_restart),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_command_kind    (m_command_kind),
        .m_source_offset   (m_source_offset),
        .m_dest_offset     (m_dest_offset),
        .m_offset_overflow (m_offset_overflow),
        .m_final_command   (m_final_command)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #40000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) board.predict_tick(s_restart);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_command(m_command_kind, m_source_offset, m_dest_offset,
                                m_offset_overflow, m_final_command);
    end

    initial begin
        int pause;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            pause = no_idle ? 0 : $urandom_range(0, 9);
            if (pause > 0) begin
                m_ready <= 1'b0;
                repeat (pause) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(0, 15))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(1, 3));
        endcase
    endfunction

    function automatic logic [15:0] pick_stride();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_tick(input bit restart);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_restart <= restart;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic run_walk(input bit with_restart, input int ticks, input int break_at);
        if (with_restart) send_tick(1'b1);
        for (int i = 0; i < ticks; i++) send_tick(i == break_at);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_e idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_reg(idx, value);
        @(posedge aclk);
    endtask

    task automatic random_config(input logic [5:0] which);
        logic [63:0] dims_word, in_str, out_str;
        logic [2:0]  rank, kept;
        for (int k = 0; k < 4; k++) begin
            dims_word[k*16 +: 16] = pick_dim();
            in_str[k*16 +: 16]    = pick_stride();
            out_str[k*16 +: 16]   = pick_stride();
        end
        rank = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
        kept = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 3));
        if (which[REG_INPUT_RANK])     write_reg(REG_INPUT_RANK, 64'(rank));
        if (which[REG_INPUT_DIMS])     write_reg(REG_INPUT_DIMS, dims_word);
        if (which[REG_INPUT_STRIDES])  write_reg(REG_INPUT_STRIDES, in_str);
        if (which[REG_KEPT_COUNT])     write_reg(REG_KEPT_COUNT, 64'(kept));
        if (which[REG_KEPT_AXES])      write_reg(REG_KEPT_AXES, 64'($urandom_range(0, 255)));
        if (which[REG_OUTPUT_STRIDES]) write_reg(REG_OUTPUT_STRIDES, out_str);
    endtask

    initial begin
        int              sent, scen, ticks, cut, extra;
        longint unsigned walk;
        no_idle          = 1'b0;
        hold_off_request = 1'b0;
        aresetn   <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        s_valid   <= 1'b0;
        s_restart <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: an idle tick, a restart, one zero-write that also ends the empty-input walk, an idle tick.
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        settle();

        write_reg(REG_INPUT_RANK, 64'd2);
        write_reg(REG_INPUT_DIMS, 64'h0000_0000_0002_0003);
        write_reg(REG_INPUT_STRIDES, 64'h0000_0000_0003_0001);
        write_reg(REG_KEPT_COUNT, 64'd1);
        write_reg(REG_KEPT_AXES, 64'h01);
        write_reg(REG_OUTPUT_STRIDES, 64'h1);
        run_walk(1'b1, 8, -1);
        settle();

        // The kept axis now has length zero, so the restart leaves nothing to issue.
        write_reg(REG_INPUT_DIMS, 64'h0000_0000_0000_0003);
        run_walk(1'b1, 1, -1);
        settle();

        write_reg(REG_INPUT_RANK, 64'd0);
        write_reg(REG_KEPT_COUNT, 64'd2);
        write_reg(REG_KEPT_AXES, 64'h03);
        run_walk(1'b1, 2, -1);
        settle();

        write_reg(REG_INPUT_RANK, 64'd7);
        write_reg(REG_INPUT_DIMS, '1);
        write_reg(REG_INPUT_STRIDES, '1);
        write_reg(REG_KEPT_COUNT, 64'd7);
        write_reg(REG_KEPT_AXES, 64'hE4);
        write_reg(REG_OUTPUT_STRIDES, '1);
        run_walk(1'b1, 3, -1);
        settle();

        // A long walk on one axis drives its counter high enough for the destination
        // offset to overflow once all four output axes map onto it.
        write_reg(REG_INPUT_RANK, 64'd1);
        write_reg(REG_INPUT_DIMS, 64'hFFFF);
        write_reg(REG_KEPT_COUNT, 64'd0);
        no_idle          = 1'b1;
        hold_off_request = 1'b1;
        run_walk(1'b1, DEEP_WALK, -1);
        settle();
        write_reg(REG_KEPT_COUNT, 64'd4);
        write_reg(REG_KEPT_AXES, 64'h00);
        write_reg(REG_OUTPUT_STRIDES, '1);
        run_walk(1'b0, 20, -1);
        settle();
        no_idle = 1'b0;

        sent = 0;
        scen = 0;
        while (sent < RANDOM_TICKS) begin
            random_config((scen == 0) ? 6'h3F : 6'($urandom_range(1, 63)));
            no_idle = ($urandom_range(0, 5) == 0);
            if (scen == 7) hold_off_request = 1'b1;
            walk  = board.commands_in_walk();
            ticks = ((walk > WALK_TICK_CAP) ? WALK_TICK_CAP : int'(walk)) + $urandom_range(0, 2);
            cut   = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, ticks)) : -1;
            if ($urandom_range(0, 9) == 0) begin
                extra = $urandom_range(1, 5);
                run_walk(1'b0, extra, -1);
                sent += extra;
            end
            run_walk(1'b1, ticks, cut);
            sent += ticks + 1;
            if ($urandom_range(0, 5) == 0) begin
                settle();
                random_config(6'(1 << $urandom_range(0, 5)));
                extra = $urandom_range(1, 20);
                run_walk(1'b0, extra, -1);
                sent += extra;
            end
            settle();
            scen++;
        end
        no_idle = 1'b0;
        settle();

        if (board.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
